>>> rtl/tekd_pkg.sv
// tekd_pkg: types and constants shared by the terminal escape key decoder
// holds payload structs, controller/datapath command and status structs, byte codes
// no dependencies
`default_nettype none

package tekd_pkg;

    localparam int WIN_BYTES = 6;

    typedef logic [WIN_BYTES-1:0][7:0] win_t;
    typedef logic [2:0] count_t;

    // escape sequence bytes
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_LBRACK = 8'h5B;
    localparam logic [7:0] BYTE_ONE    = 8'h31;
    localparam logic [7:0] BYTE_SEMI   = 8'h3B;
    localparam logic [7:0] BYTE_MOUSE  = 8'h4D;
    localparam logic [7:0] BYTE_THREE  = 8'h33;
    localparam logic [7:0] BYTE_TILDE  = 8'h7E;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_ARR_A  = 8'h41;
    localparam logic [7:0] BYTE_ARR_B  = 8'h42;
    localparam logic [7:0] BYTE_ARR_C  = 8'h43;
    localparam logic [7:0] BYTE_ARR_D  = 8'h44;

    // special key codes
    localparam logic [3:0] CODE_NONE   = 4'd0;
    localparam logic [3:0] CODE_TAB    = 4'd1;
    localparam logic [3:0] CODE_ENTER  = 4'd2;
    localparam logic [3:0] CODE_ESC    = 4'd3;
    localparam logic [3:0] CODE_UP     = 4'd4;
    localparam logic [3:0] CODE_DOWN   = 4'd5;
    localparam logic [3:0] CODE_LEFT   = 4'd6;
    localparam logic [3:0] CODE_RIGHT  = 4'd7;
    localparam logic [3:0] CODE_DELETE = 4'd8;

    // x10 mouse button bytes after removing the 32 offset
    localparam logic [7:0] MB_LEFT    = 8'd0;
    localparam logic [7:0] MB_RELEASE = 8'd3;
    localparam logic [7:0] MB_WHEEL_U = 8'd64;
    localparam logic [7:0] MB_WHEEL_D = 8'd65;

    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_WHEEL_U = 2'd1;
    localparam logic [1:0] BTN_WHEEL_D = 2'd2;

    localparam logic EV_KEY   = 1'b0;
    localparam logic EV_MOUSE = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } in_item_t;

    typedef struct packed {
        logic              event_kind;
        logic              is_special;
        logic [7:0]        character;
        logic [3:0]        special_code;
        logic              ctrl_held;
        logic              alt_held;
        logic              mouse_action;
        logic [1:0]        mouse_btn;
        logic signed [7:0] mouse_col;
        logic signed [7:0] mouse_row;
        logic [2:0]        bytes_used;
        logic              last_of_run;
    } out_item_t;

    typedef struct packed {
        logic append;   // write the accepted byte at the window tail
        logic emit;     // load one decoded event into the output register
        logic last;     // event is the final one of this run
    } dp_cmd_t;

    typedef struct packed {
        count_t count;
        logic   cnt_at_five;
        logic   rem_zero;   // head event consumes every buffered byte
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/terminal_escape_key_decoder.sv
// Terminal escape key decoder: turns a raw terminal byte stream into key and
// mouse events (arrows with modifiers, X10 mouse, delete, alt+key, ctrl+letter).
// Bytes are taken one per cycle, while no event is being decoded, into a
// six-byte window. A transaction that neither fills the window nor carries
// chunk_end only buffers its byte and produces no event. When the window fills,
// one event is decoded from its head once the output register is free; at chunk
// end the window is drained, one event per cycle while results are taken, so one
// input transaction can give up to six events. The event output is registered,
// so once the final event of a run is loaded, buffering of new bytes continues
// while it waits to be taken. bytes_used tells how many stream bytes each event
// consumed and last_of_run marks the final event caused by one input byte.
// depends on tekd_pkg, tekd_ctrl, tekd_dp
`default_nettype none

module terminal_escape_key_decoder (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire tekd_pkg::in_item_t   s_payload,
    output logic                      m_valid,
    input  wire                       m_ready,
    output tekd_pkg::out_item_t       m_payload
);

    tekd_pkg::dp_cmd_t  cmd;
    tekd_pkg::dp_stat_t stat;

    tekd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .chunk_end (s_payload.chunk_end),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tekd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (s_payload.data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (m_payload)
    );

    // window never full while bytes are being taken
    a_room_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> stat.count <= 3'd5)
        else $error("window full while accepting input");

    // decoding always has at least one buffered byte
    a_decode_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> stat.count != 3'd0)
        else $error("decode with empty window");

    // a plain buffering transaction never blocks the next byte
    a_buffer_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_payload.chunk_end && !stat.cnt_at_five) |=> s_ready)
        else $error("input stalled after buffering transaction");

    // every event consumes one to six bytes
    a_used_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.bytes_used != 3'd0 && m_payload.bytes_used != 3'd7))
        else $error("event bytes_used out of range");

endmodule

`default_nettype wire

>>> rtl/tekd_decode.sv
// tekd_decode: combinational decode of one event from the head of the byte window
// depends on tekd_pkg
`default_nettype none

module tekd_decode (
    input  wire tekd_pkg::win_t      win,
    input  wire tekd_pkg::count_t    count,
    output tekd_pkg::out_item_t      ev
);

    typedef struct packed {
        logic       is_special;
        logic [3:0] code;
        logic [7:0] character;
        logic       ctrl;
    } key_t;

    function automatic logic [3:0] arrow_code(input logic [7:0] f);
        logic [3:0] c;
        case (f)
            tekd_pkg::BYTE_ARR_A: c = tekd_pkg::CODE_UP;
            tekd_pkg::BYTE_ARR_B: c = tekd_pkg::CODE_DOWN;
            tekd_pkg::BYTE_ARR_C: c = tekd_pkg::CODE_RIGHT;
            tekd_pkg::BYTE_ARR_D: c = tekd_pkg::CODE_LEFT;
            default:              c = tekd_pkg::CODE_NONE;
        endcase
        return c;
    endfunction

    function automatic key_t decode_single(input logic [7:0] b);
        key_t       k;
        logic [7:0] r;
        k = '0;
        r = b + 8'd96;
        if (b == tekd_pkg::BYTE_TAB) begin
            k.is_special = 1'b1;
            k.code       = tekd_pkg::CODE_TAB;
        end else if (b == tekd_pkg::BYTE_CR) begin
            k.is_special = 1'b1;
            k.code       = tekd_pkg::CODE_ENTER;
        end else if (b == tekd_pkg::BYTE_ESC) begin
            k.is_special = 1'b1;
            k.code       = tekd_pkg::CODE_ESC;
        end else if (b[6:5] == 2'b00) begin
            // control byte maps to ctrl plus a character, printable for the C0 range
            if (b == 8'd0) begin
                r = 8'd32;
            end else if (r < 8'd97 || r > 8'd122) begin
                r = b + 8'd24;
            end
            k.character = r;
            k.ctrl      = 1'b1;
        end else begin
            k.character = b;
        end
        return k;
    endfunction

    logic       esc_lb;
    logic [7:0] mod_m;
    logic [7:0] btn_b;
    logic       mouse_ok;
    key_t       key0;
    key_t       key1;

    always_comb begin
        esc_lb   = (win[0] == tekd_pkg::BYTE_ESC) && (win[1] == tekd_pkg::BYTE_LBRACK);
        mod_m    = win[4] - 8'd33;
        btn_b    = win[3] - 8'd32;
        mouse_ok = (btn_b == tekd_pkg::MB_LEFT) || (btn_b == tekd_pkg::MB_RELEASE) ||
                   (btn_b == tekd_pkg::MB_WHEEL_U) || (btn_b == tekd_pkg::MB_WHEEL_D);
        key0     = decode_single(win[0]);
        key1     = decode_single(win[1]);
        ev       = '0;
        if (count == 3'd6 && esc_lb && win[2] == tekd_pkg::BYTE_ONE &&
            win[3] == tekd_pkg::BYTE_SEMI) begin
            ev.is_special   = 1'b1;
            ev.special_code = arrow_code(win[5]);
            ev.alt_held     = mod_m[1];
            ev.ctrl_held    = mod_m[2];
            ev.bytes_used   = 3'd6;
        end else if (count == 3'd6 && esc_lb && win[2] == tekd_pkg::BYTE_MOUSE &&
                     mouse_ok) begin
            ev.event_kind   = tekd_pkg::EV_MOUSE;
            ev.mouse_action = (btn_b == tekd_pkg::MB_RELEASE);
            if (btn_b == tekd_pkg::MB_WHEEL_U) begin
                ev.mouse_btn = tekd_pkg::BTN_WHEEL_U;
            end else if (btn_b == tekd_pkg::MB_WHEEL_D) begin
                ev.mouse_btn = tekd_pkg::BTN_WHEEL_D;
            end else begin
                ev.mouse_btn = tekd_pkg::BTN_LEFT;
            end
            ev.mouse_col  = win[4] - 8'd32;
            ev.mouse_row  = win[5] - 8'd32;
            ev.bytes_used = 3'd6;
        end else if (count >= 3'd4 && esc_lb && win[2] == tekd_pkg::BYTE_THREE &&
                     win[3] == tekd_pkg::BYTE_TILDE) begin
            ev.is_special   = 1'b1;
            ev.special_code = tekd_pkg::CODE_DELETE;
            ev.bytes_used   = 3'd4;
        end else if (count >= 3'd3 && esc_lb) begin
            ev.is_special   = 1'b1;
            ev.special_code = arrow_code(win[2]);
            ev.bytes_used   = 3'd3;
        end else if (count >= 3'd2 && win[0] == tekd_pkg::BYTE_ESC) begin
            ev.is_special   = key1.is_special;
            ev.special_code = key1.code;
            ev.character    = key1.character;
            ev.ctrl_held    = key1.ctrl;
            ev.alt_held     = 1'b1;
            ev.bytes_used   = 3'd2;
        end else begin
            ev.is_special   = key0.is_special;
            ev.special_code = key0.code;
            ev.character    = key0.character;
            ev.ctrl_held    = key0.ctrl;
            ev.bytes_used   = 3'd1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tekd_dp.sv
// tekd_dp: byte window, fill count, event decoder and output register
// depends on tekd_pkg and tekd_decode
`default_nettype none

module tekd_dp (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire [7:0]                 data_byte,
    input  wire tekd_pkg::dp_cmd_t    cmd,
    output tekd_pkg::dp_stat_t        stat,
    output tekd_pkg::out_item_t       out_item
);

    tekd_pkg::win_t      win_reg;
    tekd_pkg::win_t      win_next;
    tekd_pkg::count_t    cnt_reg;
    tekd_pkg::count_t    cnt_next;
    tekd_pkg::out_item_t out_reg;
    tekd_pkg::out_item_t out_next;
    tekd_pkg::out_item_t ev;

    tekd_decode u_decode (
        .win   (win_reg),
        .count (cnt_reg),
        .ev    (ev)
    );

    always_comb begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        out_next = out_reg;
        if (cmd.append) begin
            win_next[cnt_reg] = data_byte;
            cnt_next          = cnt_reg + 3'd1;
        end else if (cmd.emit) begin
            // drop the consumed bytes from the window head
            win_next = win_reg >> {ev.bytes_used, 3'b000};
            cnt_next = cnt_reg - ev.bytes_used;
        end
        if (cmd.emit) begin
            out_next             = ev;
            out_next.last_of_run = cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        out_reg <= out_next;
    end

    always_comb begin
        stat.count       = cnt_reg;
        stat.cnt_at_five = (cnt_reg == 3'd5);
        stat.rem_zero    = (cnt_reg == ev.bytes_used);
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

>>> rtl/tekd_ctrl.sv
// tekd_ctrl: controller for buffering and event emission, owns both handshakes
// depends on tekd_pkg
`default_nettype none

module tekd_ctrl (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    input  wire                       chunk_end,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire                       m_ready,
    input  wire tekd_pkg::dp_stat_t   stat,
    output tekd_pkg::dp_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_DECODE
    } state_t;

    state_t state_reg;
    logic   end_reg;
    logic   m_valid_reg;
    logic   out_free;

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        cmd.append = (state_reg == ST_IDLE) && s_valid;
        cmd.emit   = (state_reg == ST_DECODE) && out_free;
        // a full-window decode emits one event; a chunk end drains everything
        cmd.last   = !end_reg || stat.rem_zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        end_reg <= chunk_end;
                        if (chunk_end || stat.cnt_at_five) begin
                            state_reg <= ST_DECODE;
                        end
                    end
                end
                ST_DECODE: begin
                    if (cmd.emit && cmd.last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> dv/tekd_event_checker.sv
// tekd_event_checker: watches both channels of the terminal escape key decoder,
// predicts the key and mouse events of every accepted byte and compares them in order
// depends on tekd_pkg
module tekd_event_checker (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    input  wire                      s_ready,
    input  wire tekd_pkg::in_item_t  s_payload,
    input  wire                      m_valid,
    input  wire                      m_ready,
    input  wire tekd_pkg::out_item_t m_payload,
    output int                       mismatch_count,
    output int                       events_waiting,
    output int                       events_checked,
    output int                       mouse_events,
    output int                       special_events
);

    localparam logic [7:0] BYTE_NUL        = 8'h00;
    localparam logic [7:0] CTRL_GROUP_MASK = 8'h60;
    localparam logic [7:0] CTRL_SPACE      = 8'h20;
    localparam logic [7:0] LOWER_A         = 8'h61;
    localparam logic [7:0] LOWER_Z         = 8'h7A;
    localparam logic [7:0] LOWER_SHIFT     = 8'd96;
    localparam logic [7:0] UPPER_SHIFT     = 8'd24;
    localparam logic [7:0] MOD_BIAS        = 8'd33;
    localparam logic [7:0] X10_BIAS        = 8'd32;
    localparam int         REPORT_LIMIT    = 30;

    tekd_pkg::out_item_t expected_events [$];
    logic [7:0]          held_bytes [0:4];
    int unsigned         held_count;

    function automatic logic [3:0] arrow_code(input logic [7:0] final_byte);
        case (final_byte)
            tekd_pkg::BYTE_ARR_A: return tekd_pkg::CODE_UP;
            tekd_pkg::BYTE_ARR_B: return tekd_pkg::CODE_DOWN;
            tekd_pkg::BYTE_ARR_C: return tekd_pkg::CODE_RIGHT;
            tekd_pkg::BYTE_ARR_D: return tekd_pkg::CODE_LEFT;
            default:              return tekd_pkg::CODE_NONE;
        endcase
    endfunction

    function automatic tekd_pkg::out_item_t key_event(input logic [7:0] b);
        tekd_pkg::out_item_t ev;
        logic [7:0]          shifted;
        ev = '0;
        if (b == tekd_pkg::BYTE_TAB) begin
            ev.is_special   = 1'b1;
            ev.special_code = tekd_pkg::CODE_TAB;
        end else if (b == tekd_pkg::BYTE_CR) begin
            ev.is_special   = 1'b1;
            ev.special_code = tekd_pkg::CODE_ENTER;
        end else if (b == tekd_pkg::BYTE_ESC) begin
            ev.is_special   = 1'b1;
            ev.special_code = tekd_pkg::CODE_ESC;
        end else if ((b & CTRL_GROUP_MASK) == BYTE_NUL) begin
            // control byte: ctrl+letter where the letter lands in a..z, else NUL gives space and others b+24
            shifted = b + LOWER_SHIFT;
            if (b == BYTE_NUL)
                shifted = CTRL_SPACE;
            else if (shifted < LOWER_A || shifted > LOWER_Z)
                shifted = b + UPPER_SHIFT;
            ev.character = shifted;
            ev.ctrl_held = 1'b1;
        end else begin
            ev.character = b;
        end
        return ev;
    endfunction

    // decode one event from the window head at off, longest form first
    function automatic tekd_pkg::out_item_t decode_head(input tekd_pkg::win_t w,
                                                        input int unsigned rem_len,
                                                        input int unsigned off);
        tekd_pkg::out_item_t ev;
        logic [7:0]          b [0:5];
        logic [7:0]          mods;
        logic [7:0]          btn;
        for (int k = 0; k < 6; k++)
            b[k] = (off + k < tekd_pkg::WIN_BYTES) ? w[off + k] : BYTE_NUL;
        ev = '0;
        if (rem_len >= 6 && b[0] == tekd_pkg::BYTE_ESC && b[1] == tekd_pkg::BYTE_LBRACK) begin
            if (b[2] == tekd_pkg::BYTE_ONE && b[3] == tekd_pkg::BYTE_SEMI) begin
                mods            = b[4] - MOD_BIAS;
                ev.is_special   = 1'b1;
                ev.special_code = arrow_code(b[5]);
                ev.alt_held     = mods[1];
                ev.ctrl_held    = mods[2];
                ev.bytes_used   = 3'd6;
                return ev;
            end
            if (b[2] == tekd_pkg::BYTE_MOUSE) begin
                btn = b[3] - X10_BIAS;
                if (btn == tekd_pkg::MB_LEFT || btn == tekd_pkg::MB_RELEASE ||
                    btn == tekd_pkg::MB_WHEEL_U || btn == tekd_pkg::MB_WHEEL_D) begin
                    ev.event_kind   = tekd_pkg::EV_MOUSE;
                    ev.mouse_action = (btn == tekd_pkg::MB_RELEASE);
                    ev.mouse_btn    = (btn == tekd_pkg::MB_WHEEL_U) ? tekd_pkg::BTN_WHEEL_U :
                                      (btn == tekd_pkg::MB_WHEEL_D) ? tekd_pkg::BTN_WHEEL_D :
                                                                      tekd_pkg::BTN_LEFT;
                    ev.mouse_col    = b[4] - X10_BIAS;
                    ev.mouse_row    = b[5] - X10_BIAS;
                    ev.bytes_used   = 3'd6;
                    return ev;
                end
            end
        end
        if (rem_len >= 4 && b[0] == tekd_pkg::BYTE_ESC && b[1] == tekd_pkg::BYTE_LBRACK &&
            b[2] == tekd_pkg::BYTE_THREE && b[3] == tekd_pkg::BYTE_TILDE) begin
            ev.is_special   = 1'b1;
            ev.special_code = tekd_pkg::CODE_DELETE;
            ev.bytes_used   = 3'd4;
            return ev;
        end
        if (rem_len >= 3 && b[0] == tekd_pkg::BYTE_ESC && b[1] == tekd_pkg::BYTE_LBRACK) begin
            ev.is_special   = 1'b1;
            ev.special_code = arrow_code(b[2]);
            ev.bytes_used   = 3'd3;
            return ev;
        end
        if (rem_len >= 2 && b[0] == tekd_pkg::BYTE_ESC) begin
            ev            = key_event(b[1]);
            ev.alt_held   = 1'b1;
            ev.bytes_used = 3'd2;
            return ev;
        end
        ev            = key_event(b[0]);
        ev.bytes_used = 3'd1;
        return ev;
    endfunction

    task automatic predict_from_byte(input tekd_pkg::in_item_t item);
        tekd_pkg::win_t      win;
        int unsigned         n;
        int unsigned         off;
        int unsigned         cnt;
        tekd_pkg::out_item_t evs [0:5];
        if (held_count + 1 < tekd_pkg::WIN_BYTES && !item.chunk_end) begin
            held_bytes[held_count] = item.data_byte;
            held_count++;
            return;
        end
        win = '0;
        n   = held_count;
        for (int i = 0; i < n; i++)
            win[i] = held_bytes[i];
        win[n] = item.data_byte;
        n++;
        off = 0;
        cnt = 0;
        // a full window gives one event, a chunk end drains everything
        do begin
            evs[cnt] = decode_head(win, n - off, off);
            off += evs[cnt].bytes_used;
            cnt++;
        end while (item.chunk_end && off < n);
        evs[cnt - 1].last_of_run = 1'b1;
        for (int i = 0; i < cnt; i++)
            expected_events.push_back(evs[i]);
        held_count = n - off;
        for (int i = 0; i < held_count; i++)
            held_bytes[i] = win[off + i];
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] event %0d %s: got %h, expected %h",
                     $time, events_checked, what, got, want);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    task automatic check_event(input tekd_pkg::out_item_t got);
        tekd_pkg::out_item_t want;
        if (expected_events.size() == 0) begin
            report_mismatch("event with nothing expected", got, '0);
            return;
        end
        want = expected_events.pop_front();
        events_checked++;
        if (want.event_kind == tekd_pkg::EV_MOUSE)
            mouse_events++;
        if (want.is_special)
            special_events++;
        compare_field("event_kind", got.event_kind, want.event_kind);
        compare_field("is_special", got.is_special, want.is_special);
        compare_field("character", got.character, want.character);
        compare_field("special_code", got.special_code, want.special_code);
        compare_field("ctrl_held", got.ctrl_held, want.ctrl_held);
        compare_field("alt_held", got.alt_held, want.alt_held);
        compare_field("mouse_action", got.mouse_action, want.mouse_action);
        compare_field("mouse_btn", got.mouse_btn, want.mouse_btn);
        compare_field("mouse_col", got.mouse_col, want.mouse_col);
        compare_field("mouse_row", got.mouse_row, want.mouse_row);
        compare_field("bytes_used", got.bytes_used, want.bytes_used);
        compare_field("last_of_run", got.last_of_run, want.last_of_run);
    endtask

    // results are checked before the same edge's input is predicted
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_events.delete();
            held_count = 0;
        end else begin
            if (m_valid === 1'b1 && m_ready === 1'b1)
                check_event(m_payload);
            if (s_valid === 1'b1 && s_ready === 1'b1)
                predict_from_byte(s_payload);
        end
        events_waiting = expected_events.size();
    end

endmodule

>>> dv/terminal_escape_key_decoder_test.sv
// terminal_escape_key_decoder_test: feeds directed and random terminal byte streams
// with random gaps and stalls, the event checker judges every result
// depends on tekd_pkg, terminal_escape_key_decoder, tekd_event_checker
module terminal_escape_key_decoder_test;

    localparam int DIRECTED_BYTES  = 25;
    localparam int RANDOM_BYTES    = 95;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 12;

    typedef enum int {
        SEQ_MOD_ARROW,
        SEQ_MOUSE,
        SEQ_DELETE,
        SEQ_ARROW,
        SEQ_ALT_KEY,
        SEQ_SINGLE,
        SEQ_NOISE
    } seq_kind_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    tekd_pkg::in_item_t  s_payload;
    logic                m_valid;
    logic                m_ready;
    tekd_pkg::out_item_t m_payload;

    int mismatch_count;
    int events_waiting;
    int events_checked;
    int mouse_events;
    int special_events;

    int         bytes_sent;
    int         idle_cycles;
    logic       calm;
    logic       hold_req;
    logic       hold_done;
    logic [7:0] seq_bytes [0:5];
    int         seq_len;
    logic       end_chunk;

    terminal_escape_key_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    tekd_event_checker i_event_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .mismatch_count (mismatch_count),
        .events_waiting (events_waiting),
        .events_checked (events_checked),
        .mouse_events   (mouse_events),
        .special_events (special_events)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // no gap when calm, else mostly none, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_final();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return tekd_pkg::BYTE_ARR_A;
            1:       return tekd_pkg::BYTE_ARR_B;
            2:       return tekd_pkg::BYTE_ARR_C;
            default: return tekd_pkg::BYTE_ARR_D;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        tekd_pkg::in_item_t item;
        int                 gap;
        item.data_byte = b;
        item.chunk_end = last_byte;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic build_seq(input seq_kind_t kind);
        seq_bytes[0] = tekd_pkg::BYTE_ESC;
        seq_bytes[1] = tekd_pkg::BYTE_LBRACK;
        case (kind)
            SEQ_MOD_ARROW: begin
                seq_bytes[2] = tekd_pkg::BYTE_ONE;
                seq_bytes[3] = tekd_pkg::BYTE_SEMI;
                // modifier bytes 8'h21..8'h28 half of the time, any byte otherwise
                seq_bytes[4] = $urandom_range(0, 1) ? 8'($urandom_range(8'h21, 8'h28))
                                                    : 8'($urandom_range(0, 255));
                seq_bytes[5] = pick_final();
                seq_len = 6;
            end
            SEQ_MOUSE: begin
                seq_bytes[2] = tekd_pkg::BYTE_MOUSE;
                case ($urandom_range(0, 4))
                    0:       seq_bytes[3] = tekd_pkg::MB_LEFT + 8'd32;
                    1:       seq_bytes[3] = tekd_pkg::MB_RELEASE + 8'd32;
                    2:       seq_bytes[3] = tekd_pkg::MB_WHEEL_U + 8'd32;
                    3:       seq_bytes[3] = tekd_pkg::MB_WHEEL_D + 8'd32;
                    default: seq_bytes[3] = 8'($urandom_range(0, 255));
                endcase
                seq_bytes[4] = 8'($urandom_range(0, 255));
                seq_bytes[5] = 8'($urandom_range(0, 255));
                seq_len = 6;
            end
            SEQ_DELETE: begin
                seq_bytes[2] = tekd_pkg::BYTE_THREE;
                seq_bytes[3] = tekd_pkg::BYTE_TILDE;
                seq_len = 4;
            end
            SEQ_ARROW: begin
                seq_bytes[2] = pick_final();
                seq_len = 3;
            end
            SEQ_ALT_KEY: begin
                seq_bytes[1] = 8'($urandom_range(0, 255));
                seq_len = 2;
            end
            SEQ_SINGLE: begin
                if ($urandom_range(0, 1))
                    seq_bytes[0] = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 2'b00,
                                    5'($urandom_range(0, 31))};
                else
                    seq_bytes[0] = 8'($urandom_range(0, 255));
                seq_len = 1;
            end
            default: begin
                seq_len = $urandom_range(1, 6);
                for (int i = 0; i < 6; i++)
                    seq_bytes[i] = 8'($urandom_range(0, 255));
            end
        endcase
    endtask

    task automatic send_seq(input logic close_chunk);
        for (int i = 0; i < seq_len; i++)
            send_byte(seq_bytes[i], close_chunk && (i == seq_len - 1));
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int gap;
        m_ready   = 1'b0;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d events still expected",
                 STALL_LIMIT, events_waiting);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_payload  = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        bytes_sent = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // modified arrow with ctrl and alt, filling the window
        send_byte(tekd_pkg::BYTE_ESC, 1'b0);
        send_byte(tekd_pkg::BYTE_LBRACK, 1'b0);
        send_byte(tekd_pkg::BYTE_ONE, 1'b0);
        send_byte(tekd_pkg::BYTE_SEMI, 1'b0);
        send_byte(8'h27, 1'b0);
        send_byte(tekd_pkg::BYTE_ARR_A, 1'b0);
        // mouse release at the column and row extremes
        send_byte(tekd_pkg::BYTE_ESC, 1'b0);
        send_byte(tekd_pkg::BYTE_LBRACK, 1'b0);
        send_byte(tekd_pkg::BYTE_MOUSE, 1'b0);
        send_byte(tekd_pkg::MB_RELEASE + 8'd32, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // delete in a short chunk
        send_byte(tekd_pkg::BYTE_ESC, 1'b0);
        send_byte(tekd_pkg::BYTE_LBRACK, 1'b0);
        send_byte(tekd_pkg::BYTE_THREE, 1'b0);
        send_byte(tekd_pkg::BYTE_TILDE, 1'b1);
        // arrow with an unknown final byte
        send_byte(tekd_pkg::BYTE_ESC, 1'b0);
        send_byte(tekd_pkg::BYTE_LBRACK, 1'b0);
        send_byte(8'h5A, 1'b1);
        // alt plus ctrl space
        send_byte(tekd_pkg::BYTE_ESC, 1'b0);
        send_byte(8'h00, 1'b1);
        // high byte, c1 control byte, tab and enter drained together
        send_byte(8'hFF, 1'b0);
        send_byte(8'h9A, 1'b0);
        send_byte(tekd_pkg::BYTE_TAB, 1'b0);
        send_byte(tekd_pkg::BYTE_CR, 1'b1);

        while (bytes_sent < DIRECTED_BYTES + RANDOM_BYTES) begin
            if (!hold_req && bytes_sent >= DIRECTED_BYTES + 40) begin
                // keep offering printable bytes while the result side is held off
                calm     = 1'b1;
                hold_req = 1'b1;
                repeat (16) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b1);
                calm = 1'b0;
            end else begin
                calm = ($urandom_range(0, 4) == 0);
                build_seq(seq_kind_t'($urandom_range(0, 6)));
                end_chunk = ($urandom_range(0, 9) < 6);
                // broken sequence: cut short and closed by the chunk end
                if (seq_len > 1 && $urandom_range(0, 6) == 0) begin
                    seq_len   = $urandom_range(1, seq_len - 1);
                    end_chunk = 1'b1;
                end
                send_seq(end_chunk);
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        wait (events_waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d input bytes: modified arrows, x10 mouse, delete, arrows,",
                 bytes_sent);
        $display("alt and ctrl keys, noise; %0d events compared (%0d mouse, %0d named keys)",
                 events_checked, mouse_events, special_events);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
